[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk_i, off while rst_ni is low.
`define RMTS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, but also checked while in reset.
`define RMTS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/rmts_pkg.sv]
package rmts_pkg;

  localparam int unsigned MaxSlots   = 8;
  localparam int unsigned SlotIdxW   = 3;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned FieldW     = 16;
  localparam int unsigned DefSlotCnt = 8;
  localparam int unsigned DefTimeW   = 16;

  localparam logic [CfgDataW-1:0] TimingReset = 32'h0001_0000;

  // Selection token handed from cell to cell.
  typedef struct packed {
    logic                found;
    logic [SlotIdxW-1:0] idx;
  } sel_t;

endpackage

[src/rmts_cell.sv]
module rmts_cell #(
  parameter int unsigned TIME_BITS = rmts_pkg::DefTimeW,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          restart_i,
  input  logic [rmts_pkg::CfgDataW-1:0] timing_i,
  input  rmts_pkg::sel_t                sel_i,
  input  logic [TIME_BITS-1:0]          per_i,
  output rmts_pkg::sel_t                sel_o,
  output logic [TIME_BITS-1:0]          per_o,
  input  rmts_pkg::sel_t                winner_i,
  output logic                          release_o,
  output logic                          miss_o
);
  import rmts_pkg::*;

  logic [TIME_BITS-1:0] phase_q, phase_d;
  logic [TIME_BITS-1:0] work_q, work_d;
  logic [TIME_BITS-1:0] per_raw, per, exec_t;
  logic [TIME_BITS-1:0] ph, wk, wk_rel;
  logic [TIME_BITS:0]   nx;
  logic                 en, ready, take, win;

  if (TIME_BITS >= FieldW) begin : g_wide
    assign per_raw = TIME_BITS'(timing_i[31:16]);
    assign exec_t  = TIME_BITS'(timing_i[15:0]);
  end else begin : g_narrow
    assign per_raw = timing_i[16 +: TIME_BITS];
    assign exec_t  = timing_i[TIME_BITS-1:0];
  end

  // zero period counts as one
  assign per = (per_raw == '0) ? TIME_BITS'(1) : per_raw;

  always_comb begin
    ph        = restart_i ? '0 : phase_q;
    wk        = restart_i ? '0 : work_q;
    en        = (exec_t != '0);
    release_o = en && (ph == '0);
    miss_o    = release_o && (wk != '0);
    if (!en) begin
      wk_rel = '0;
    end else if (release_o) begin
      wk_rel = exec_t;
    end else begin
      wk_rel = wk;
    end
    ready = (wk_rel != '0);
  end

  // compare against the best so far; strict less keeps the lower index on ties
  always_comb begin
    take = ready && (!sel_i.found || (per < per_i));
    if (take) begin
      sel_o.found = 1'b1;
      sel_o.idx   = SlotIdxW'(CELL_IDX);
      per_o       = per;
    end else begin
      sel_o = sel_i;
      per_o = per_i;
    end
  end

  assign win = winner_i.found && (winner_i.idx == SlotIdxW'(CELL_IDX));

  always_comb begin
    nx      = {1'b0, ph} + (TIME_BITS+1)'(1);
    work_d  = win ? (wk_rel - TIME_BITS'(1)) : wk_rel;
    if (!en || (nx >= {1'b0, per})) begin
      phase_d = '0;
    end else begin
      phase_d = nx[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      work_q  <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
      work_q  <= work_d;
    end
  end

endmodule

[src/rate_monotonic_tick_scheduler_top.sv]
// Rate-monotonic tick scheduler, one time tick per input transfer.
// Result is registered, valid in the cycle after the tick transfer.
// Throughput: one tick per cycle when out_ready_i is high; cells update in
//   parallel and selection ripples once through the cell row in the cycle.
// Reset: counters cleared, all slot timing registers at period 1 / exec 0.
`include "assert_macros.svh"

module rate_monotonic_tick_scheduler_top #(
  parameter int unsigned SLOT_COUNT = rmts_pkg::DefSlotCnt,
  parameter int unsigned TIME_BITS  = rmts_pkg::DefTimeW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rmts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rmts_pkg::CfgDataW-1:0] cfg_data_i,
  // tick channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rmts_pkg::SlotIdxW-1:0] running_slot_o,
  output logic                          idle_o,
  output logic [rmts_pkg::MaxSlots-1:0] miss_mask_o,
  output logic [rmts_pkg::MaxSlots-1:0] release_mask_o
);
  import rmts_pkg::*;

  logic [CfgDataW-1:0]  timing_q [SLOT_COUNT];
  sel_t                 sel_chain [SLOT_COUNT+1];
  logic [TIME_BITS-1:0] per_chain [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] rel_bits, miss_bits;
  logic [MaxSlots-1:0]  rel_mask, miss_mask;
  sel_t                 winner;
  logic                 tick;

  logic                 out_valid_q;
  logic [SlotIdxW-1:0]  slot_q;
  logic                 idle_q;
  logic [MaxSlots-1:0]  miss_q, rel_q;

  // Configuration: always ready; slots past SLOT_COUNT have no effect.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        timing_q[i] <= TimingReset;
      end
    end else if (cfg_valid_i) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cfg_index_i == CfgIdxW'(i)) begin
          timing_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // Output register frees up when its result transfers out.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign tick       = in_valid_i && in_ready_o;

  // Cell row: the token enters empty and leaves carrying the winner.
  assign sel_chain[0] = '0;
  assign per_chain[0] = '0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    rmts_cell #(
      .TIME_BITS (TIME_BITS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tick_i    (tick),
      .restart_i (restart_i),
      .timing_i  (timing_q[g]),
      .sel_i     (sel_chain[g]),
      .per_i     (per_chain[g]),
      .sel_o     (sel_chain[g+1]),
      .per_o     (per_chain[g+1]),
      .winner_i  (winner),
      .release_o (rel_bits[g]),
      .miss_o    (miss_bits[g])
    );
  end

  // Winner is broadcast back so only that cell burns a unit of work.
  assign winner = sel_chain[SLOT_COUNT];

  always_comb begin
    rel_mask  = '0;
    miss_mask = '0;
    rel_mask[SLOT_COUNT-1:0]  = rel_bits;
    miss_mask[SLOT_COUNT-1:0] = miss_bits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (tick) begin
      slot_q <= winner.found ? winner.idx : '0;
      idle_q <= !winner.found;
      miss_q <= miss_mask;
      rel_q  <= rel_mask;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_slot_o = slot_q;
  assign idle_o         = idle_q;
  assign miss_mask_o    = miss_q;
  assign release_mask_o = rel_q;

  `RMTS_ASSERT(a_miss_needs_release, out_valid_o |-> ((miss_mask_o & ~release_mask_o) == '0), "miss without release")
  `RMTS_ASSERT(a_idle_slot_zero, (out_valid_o && idle_o) |-> (running_slot_o == '0), "idle result names a slot")
  `RMTS_ASSERT(a_rose_after_tick, $rose(out_valid_o) |-> $past(tick), "result without tick")
  `RMTS_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_q |-> in_ready_o, "stalled with empty output")

endmodule
